@@ hw/rtl/modbus_response_deframer_core_macros.svh @@
// Assertion macros used by the checker file mrd_checker.
`ifndef MODBUS_RESPONSE_DEFRAMER_CORE_MACROS_SVH
`define MODBUS_RESPONSE_DEFRAMER_CORE_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define MRD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define MRD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/mrd_pkg.sv @@
package mrd_pkg;

    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;
    localparam logic [7:0] FUNCTION_CODE_RESET = 8'h03;

    localparam int CFG_INDEX_W = 1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_SLAVE_ADDRESS = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FUNCTION_CODE = 1'b1;

    localparam int BYTE_W     = 8;
    localparam int POS_W      = 9;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - BYTE_W - POS_W;

    localparam int FIFO_DEPTH = 8;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int LEVEL_W    = PTR_W + 1;
    localparam int MAX_PUSH   = 2;

    typedef enum logic [3:0] {
        PH_HUNT  = 4'b0001,
        PH_ADDR  = 4'b0010,
        PH_COUNT = 4'b0100,
        PH_BODY  = 4'b1000
    } phase_t;

    typedef struct packed {
        logic             last;
        logic [POS_W-1:0] position;
        logic [BYTE_W-1:0] frame_byte;
    } result_t;

    typedef struct packed {
        logic [1:0] count;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

@@ hw/rtl/modbus_response_deframer_core.sv @@
// Each accepted s_ byte is registered in the parser, then written into the result queue that drives m_.
// Throughput: one byte per cycle while s_tready is high; a matching function byte yields two results back to back.
// An 8-entry result queue decouples the sides; s_tready drops only when it could overflow.
// Reset: synchronous, active-low aresetn; registers return to 0x01 / 0x03, hunting state.
module modbus_response_deframer_core
    import mrd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [S_TDATA_W-1:0]   s_tdata,   // [7:0] rx_byte
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [M_TDATA_W-1:0]   m_tdata,   // [7:0] frame_byte, [16:8] frame_position, pad
    output logic                   m_tlast,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data
);

    push_t              push;
    logic               busy;
    logic [LEVEL_W-1:0] level;
    logic [LEVEL_W:0]   committed;
    result_t            head;

    assign committed = {1'b0, level} + (busy ? (LEVEL_W+1)'(MAX_PUSH) : '0)
                       + (LEVEL_W+1)'(MAX_PUSH);
    assign s_tready  = aresetn && (committed <= (LEVEL_W+1)'(FIFO_DEPTH));
    assign cfg_ready = 1'b1;

    mrd_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (s_tvalid && s_tready),
        .in_byte   (s_tdata[BYTE_W-1:0]),
        .cfg_write (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .busy      (busy),
        .push      (push)
    );

    mrd_result_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .pop        (m_tvalid && m_tready),
        .out_valid  (m_tvalid),
        .out_result (head),
        .level      (level)
    );

    assign m_tdata = {{M_PAD_W{1'b0}}, head.position, head.frame_byte};
    assign m_tlast = head.last;

endmodule

@@ hw/rtl/mrd_parser.sv @@
module mrd_parser
    import mrd_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   in_accept,
    input  logic [BYTE_W-1:0]      in_byte,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]      cfg_data,
    output logic                   busy,
    output push_t                  push
);

    logic              in_valid_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [BYTE_W-1:0] slave_address_reg;
    logic [BYTE_W-1:0] function_code_reg;
    phase_t            phase_reg, phase_next;
    logic [POS_W-1:0]  remaining_reg, remaining_next;
    logic [POS_W-1:0]  position_reg, position_next;
    logic              last_byte;

    assign busy = in_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg      <= 1'b0;
            slave_address_reg <= SLAVE_ADDRESS_RESET;
            function_code_reg <= FUNCTION_CODE_RESET;
            phase_reg         <= PH_HUNT;
            remaining_reg     <= '0;
            position_reg      <= '0;
        end else begin
            in_valid_reg <= in_accept;
            if (cfg_write) begin
                case (cfg_index)
                    CFG_IDX_SLAVE_ADDRESS: slave_address_reg <= cfg_data;
                    CFG_IDX_FUNCTION_CODE: function_code_reg <= cfg_data;
                    default: ;
                endcase
            end
            phase_reg     <= phase_next;
            remaining_reg <= remaining_next;
            position_reg  <= position_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_accept) begin
            in_byte_reg <= in_byte;
        end
    end

    assign last_byte = (remaining_reg <= POS_W'(1));

    always_comb begin
        phase_next     = phase_reg;
        remaining_next = remaining_reg;
        position_next  = position_reg;
        push           = '0;
        push.first.frame_byte  = in_byte_reg;
        push.second.frame_byte = in_byte_reg;
        if (in_valid_reg) begin
            case (phase_reg)
                PH_HUNT: begin
                    if (in_byte_reg == slave_address_reg) begin
                        phase_next = PH_ADDR;
                    end
                end
                PH_ADDR: begin
                    if (in_byte_reg == function_code_reg) begin
                        push.count             = 2'd2;
                        push.first.frame_byte  = slave_address_reg;
                        push.first.position    = POS_W'(0);
                        push.second.position   = POS_W'(1);
                        phase_next             = PH_COUNT;
                        position_next          = POS_W'(2);
                    end else if (in_byte_reg == slave_address_reg) begin
                        phase_next = PH_ADDR;
                    end else begin
                        phase_next = PH_HUNT;
                    end
                end
                PH_COUNT: begin
                    push.count          = 2'd1;
                    push.first.position = POS_W'(2);
                    remaining_next      = {1'b0, in_byte_reg} + POS_W'(2);
                    position_next       = POS_W'(3);
                    phase_next          = PH_BODY;
                end
                PH_BODY: begin
                    push.count          = 2'd1;
                    push.first.position = position_reg;
                    push.first.last     = last_byte;
                    if (last_byte) begin
                        phase_next     = PH_HUNT;
                        remaining_next = '0;
                        position_next  = '0;
                    end else begin
                        remaining_next = remaining_reg - POS_W'(1);
                        position_next  = position_reg + POS_W'(1);
                    end
                end
                default: begin
                    phase_next = PH_HUNT;
                end
            endcase
        end
    end

endmodule

@@ hw/rtl/mrd_result_fifo.sv @@
module mrd_result_fifo
    import mrd_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  push_t              push,
    input  logic               pop,
    output logic               out_valid,
    output result_t            out_result,
    output logic [LEVEL_W-1:0] level
);

    result_t            entries [FIFO_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    logic [PTR_W-1:0]   wr_ptr_plus1;

    assign wr_ptr_plus1 = wr_ptr_reg + PTR_W'(1);
    assign wr_ptr_next  = wr_ptr_reg + PTR_W'(push.count);
    assign rd_ptr_next  = rd_ptr_reg + PTR_W'(pop);
    assign level_next   = level_reg + LEVEL_W'(push.count) - LEVEL_W'(pop);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            level_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push.count != 2'd0) begin
            entries[wr_ptr_reg] <= push.first;
        end
        if (push.count == 2'd2) begin
            entries[wr_ptr_plus1] <= push.second;
        end
    end

    assign out_valid  = (level_reg != '0);
    assign out_result = entries[rd_ptr_reg];
    assign level      = level_reg;

endmodule

@@ hw/rtl/mrd_checker.sv @@
`include "modbus_response_deframer_core_macros.svh"

module mrd_checker
    import mrd_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tvalid,
    input logic                   s_tready,
    input logic [S_TDATA_W-1:0]   s_tdata,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [M_TDATA_W-1:0]   m_tdata,
    input logic                   m_tlast,
    input logic                   cfg_valid,
    input logic                   cfg_ready,
    input logic [CFG_INDEX_W-1:0] cfg_index,
    input logic [BYTE_W-1:0]      cfg_data
);

    logic [POS_W-1:0] out_pos;
    logic             s_xfer;
    logic             cfg_xfer;

    assign out_pos  = m_tdata[BYTE_W +: POS_W];
    assign s_xfer   = s_tvalid && s_tready && (s_tdata != '1);
    assign cfg_xfer = cfg_valid && cfg_ready && (cfg_index == cfg_index) && (cfg_data == cfg_data);

    `MRD_ASSERT_NEXT(a_stall_holds, m_tvalid && !m_tready,
        m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result changed while stalled")
    `MRD_ASSERT_NOW(a_last_position, m_tvalid && m_tlast, out_pos >= POS_W'(4),
        "frame ended before its minimum length")
    `MRD_ASSERT_NEXT(a_header_pair, m_tvalid && m_tready && (out_pos == '0),
        m_tvalid && (out_pos == POS_W'(1)) && !m_tlast, "address not followed by function byte")
    `MRD_ASSERT_NOW(a_pad_zero, m_tvalid || s_xfer || cfg_xfer,
        m_tdata[M_TDATA_W-1:BYTE_W+POS_W] == '0, "result padding bits not zero")

endmodule

bind modbus_response_deframer_core mrd_checker u_mrd_checker (.*);

@@ tb/tb_modbus_response_deframer_core.sv @@
`timescale 1ns / 100ps

module tb_modbus_response_deframer_core;
    import mrd_pkg::*;

    class response_frame_tracker;
        logic [BYTE_W-1:0] slave_addr;
        logic [BYTE_W-1:0] func_code;
        phase_t            phase;
        logic [POS_W-1:0]  bytes_left;
        logic [POS_W-1:0]  next_pos;
        result_t           expected_bytes[$];
        int                errors;

        function new();
            slave_addr = SLAVE_ADDRESS_RESET;
            func_code  = FUNCTION_CODE_RESET;
            phase      = PH_HUNT;
            bytes_left = '0;
            next_pos   = '0;
            errors     = 0;
        endfunction

        function void write_register(logic [CFG_INDEX_W-1:0] idx, logic [BYTE_W-1:0] value);
            if (idx == CFG_IDX_SLAVE_ADDRESS) begin
                slave_addr = value;
            end else if (idx == CFG_IDX_FUNCTION_CODE) begin
                func_code = value;
            end
        endfunction

        function void push_byte(logic [BYTE_W-1:0] b, logic [POS_W-1:0] pos, logic last);
            result_t r;
            r.frame_byte = b;
            r.position   = pos;
            r.last       = last;
            expected_bytes.push_back(r);
        endfunction

        function void note_rx_byte(logic [BYTE_W-1:0] b);
            logic last;
            case (phase)
                PH_HUNT: begin
                    if (b == slave_addr) phase = PH_ADDR;
                end
                PH_ADDR: begin
                    if (b == func_code) begin
                        push_byte(slave_addr, 9'd0, 1'b0);
                        push_byte(b, 9'd1, 1'b0);
                        phase    = PH_COUNT;
                        next_pos = 9'd2;
                    end else if (b != slave_addr) begin
                        phase = PH_HUNT;
                    end
                end
                PH_COUNT: begin
                    push_byte(b, 9'd2, 1'b0);
                    bytes_left = {1'b0, b} + 9'd2;
                    next_pos   = 9'd3;
                    phase      = PH_BODY;
                end
                default: begin
                    last = (bytes_left <= 9'd1);
                    push_byte(b, next_pos, last);
                    if (last) begin
                        phase      = PH_HUNT;
                        bytes_left = '0;
                        next_pos   = '0;
                    end else begin
                        bytes_left = bytes_left - 9'd1;
                        next_pos   = next_pos + 9'd1;
                    end
                end
            endcase
        endfunction

        function void check_frame_byte(logic [M_TDATA_W-1:0] data, logic tlast);
            result_t want;
            if (expected_bytes.size() == 0) begin
                $error("unexpected frame byte %02h at position %0d",
                       data[BYTE_W-1:0], data[BYTE_W +: POS_W]);
                errors++;
            end else begin
                want = expected_bytes.pop_front();
                if (data[BYTE_W-1:0] !== want.frame_byte) begin
                    $error("frame_byte: expected %02h, got %02h",
                           want.frame_byte, data[BYTE_W-1:0]);
                    errors++;
                end
                if (data[BYTE_W +: POS_W] !== want.position) begin
                    $error("frame_position: expected %0d, got %0d",
                           want.position, data[BYTE_W +: POS_W]);
                    errors++;
                end
                if (tlast !== want.last) begin
                    $error("frame_last: expected %0b, got %0b", want.last, tlast);
                    errors++;
                end
            end
        endfunction
    endclass

    logic                   aclk      = 1'b0;
    logic                   aresetn   = 1'b0;
    logic                   s_tvalid  = 1'b0;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata   = '0;
    logic                   m_tvalid;
    logic                   m_tready  = 1'b0;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = CFG_IDX_SLAVE_ADDRESS;
    logic [BYTE_W-1:0]      cfg_data  = '0;

    response_frame_tracker tracker = new();

    logic [BYTE_W-1:0] cur_addr  = SLAVE_ADDRESS_RESET;
    logic [BYTE_W-1:0] cur_func  = FUNCTION_CODE_RESET;
    bit                src_burst = 1'b0;
    int                hold_req  = 0;
    int                bytes_sent = 0;

    always #5 aclk = ~aclk;

    modbus_response_deframer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    task automatic send_rx_byte(input logic [BYTE_W-1:0] b);
        int gap;
        bit taken;
        gap = src_burst ? 0 : $urandom_range(0, 10);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do begin
            @(negedge aclk);
            taken = s_tready;
            @(posedge aclk);
        end while (!taken);
        tracker.note_rx_byte(b);
        bytes_sent++;
    endtask

    task automatic send_frame(input int count);
        logic [BYTE_W-1:0] cnt;
        cnt = BYTE_W'(count);
        src_burst = ($urandom_range(0, 9) < 3);
        send_rx_byte(cur_addr);
        send_rx_byte(cur_func);
        send_rx_byte(cnt);
        repeat (count + 2) send_rx_byte(BYTE_W'($urandom_range(0, 255)));
    endtask

    task automatic random_traffic(input int budget);
        int                stop_at;
        int                kind;
        int                count;
        logic [BYTE_W-1:0] b;
        stop_at = bytes_sent + budget;
        while (bytes_sent < stop_at) begin
            kind = $urandom_range(0, 99);
            if (kind < 70) begin
                repeat ($urandom_range(0, 3)) begin
                    do b = BYTE_W'($urandom_range(0, 255)); while (b == cur_addr);
                    send_rx_byte(b);
                end
                if ($urandom_range(0, 99) == 0) count = 255;
                else if ($urandom_range(0, 9) < 8) count = $urandom_range(0, 8);
                else count = $urandom_range(9, 40);
                send_frame(count);
            end else if (kind < 85) begin
                send_rx_byte(cur_addr);
                do b = BYTE_W'($urandom_range(0, 255)); while (b == cur_func);
                send_rx_byte(b);
            end else begin
                repeat ($urandom_range(1, 6)) send_rx_byte(BYTE_W'($urandom_range(0, 255)));
            end
        end
    endtask

    task automatic set_header(input logic [BYTE_W-1:0] addr, input logic [BYTE_W-1:0] func);
        logic [CFG_INDEX_W-1:0] idx;
        logic [BYTE_W-1:0]      val;
        bit                     taken;
        for (int i = 0; i < 2; i++) begin
            idx = (i == 0) ? CFG_IDX_SLAVE_ADDRESS : CFG_IDX_FUNCTION_CODE;
            val = (i == 0) ? addr : func;
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            do begin
                @(negedge aclk);
                taken = cfg_ready;
                @(posedge aclk);
            end while (!taken);
            tracker.write_register(idx, val);
        end
        cfg_valid <= 1'b0;
        cur_addr = addr;
        cur_func = func;
    endtask

    task automatic wait_link_idle();
        s_tvalid <= 1'b0;
        while (tracker.expected_bytes.size() != 0) @(posedge aclk);
        // let dropped bytes still in flight clear the pipeline
        repeat (8) @(posedge aclk);
    endtask

    initial begin : frame_sink
        int                   gap;
        int                   served;
        int                   hold_done;
        bit                   taken;
        logic [M_TDATA_W-1:0] got_data;
        logic                 got_last;
        served    = 0;
        hold_done = 0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (hold_req != hold_done) begin
                gap = 400;
                hold_done++;
            end else if (served % 32 < 8) begin
                gap = 0;
            end else begin
                gap = $urandom_range(0, 10);
            end
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do begin
                @(negedge aclk);
                taken    = m_tvalid;
                got_data = m_tdata;
                got_last = m_tlast;
                @(posedge aclk);
            end while (!taken);
            tracker.check_frame_byte(got_data, got_last);
            served++;
        end
    end

    initial begin : stimulus
        logic [BYTE_W-1:0] opening [19];
        opening = '{8'h00, 8'hFF, 8'h03, 8'h01, 8'h01, 8'h03, 8'h00, 8'hFF, 8'h80,
                    8'h01, 8'h05, 8'h03, 8'h01, 8'h03, 8'h02, 8'hAA, 8'h55, 8'h12,
                    8'h34};
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // noise, repeated address, empty frame, header mismatch, short frame
        foreach (opening[i]) send_rx_byte(opening[i]);
        wait_link_idle();

        set_header(8'h00, 8'h00);
        random_traffic(340);
        wait_link_idle();

        // hold the sink off while a long frame backs up the result queue
        set_header(8'hFF, 8'h00);
        hold_req++;
        send_frame(30);
        random_traffic(300);
        wait_link_idle();

        // address equal to function code: header match wins
        set_header(8'h11, 8'h11);
        send_frame(1);
        random_traffic(340);
        wait_link_idle();

        repeat (2) begin
            set_header(BYTE_W'($urandom_range(0, 255)), BYTE_W'($urandom_range(0, 255)));
            random_traffic(300);
            wait_link_idle();
        end

        set_header(SLAVE_ADDRESS_RESET, FUNCTION_CODE_RESET);
        send_frame(255);
        random_traffic(100);
        wait_link_idle();
        repeat (20) @(posedge aclk);

        if (tracker.errors == 0 && tracker.expected_bytes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

    initial begin : watchdog
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule
